// File: rtl/tmv_pkg.sv
// tmv_pkg: shared types and constants for the ternary-weight matrix-vector core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tmv_pkg;

    // Fixed field widths
    localparam int ACT_W   = 16;
    localparam int SCALE_W = 16;
    localparam int TRIT_W  = 2;
    localparam int ROW_W   = 16;
    localparam int VLEN_W  = 13;
    localparam int RES_W   = 32;
    localparam int FRAC_SH = 12;
    localparam int CFG_W   = 16;

    // Configuration register indexes
    localparam logic CFG_VEC_LEN   = 1'b0;
    localparam logic CFG_ROW_COUNT = 1'b1;

    // Command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One operation for the back end: either an accumulator clear or one weight
    typedef struct packed {
        logic               is_clear;
        logic [TRIT_W-1:0]  trit;
        logic [ACT_W-1:0]   data;
        logic [SCALE_W-1:0] scale;
        logic               row_end;
        logic               last_row;
        logic [ROW_W-1:0]   row_idx;
    } t_op;

endpackage

// File: rtl/tmv_front.sv
// tmv_front: accepts items, keeps load/column/row positions, owns the activation store.
// Emits one registered operation per useful item. Depends on tmv_pkg.
`timescale 1ns / 1ps

module tmv_front import tmv_pkg::*; #(
    parameter int MAX_VEC_LEN = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_cmd,
    input  logic signed [ACT_W-1:0]      i_activation,
    input  logic signed [TRIT_W-1:0]     i_weight_trit,
    input  logic signed [SCALE_W-1:0]    i_row_scale,
    input  logic [$clog2(MAX_VEC_LEN+1)-1:0] i_len,
    input  logic [ROW_W-1:0]             i_rows,
    output logic                         o_pend,
    output logic                         o_push,
    output t_op                          o_op
);

    localparam int LEN_W = $clog2(MAX_VEC_LEN + 1);
    localparam int AW    = (MAX_VEC_LEN > 1) ? $clog2(MAX_VEC_LEN) : 1;

    logic [ACT_W-1:0] r_mem [MAX_VEC_LEN];
    logic [ACT_W-1:0] r_rd_data;

    logic [LEN_W-1:0] r_load_pos, n_load_pos;
    logic [AW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic               r_pend_valid, n_pend_valid;
    logic               r_pend_clear, n_pend_clear;
    logic [TRIT_W-1:0]  r_pend_trit;
    logic [SCALE_W-1:0] r_pend_scale;
    logic               r_pend_end, n_pend_end;
    logic               r_pend_last, n_pend_last;
    logic [ROW_W-1:0]   r_pend_row;

    logic            w_full;
    logic            w_is_load;
    logic            w_mem_we;
    logic            w_mem_re;
    logic [AW-1:0]   w_waddr;
    logic            w_row_end;
    logic            w_last;

    assign w_is_load = (i_cmd == CMD_LOAD);
    assign w_full    = (r_load_pos >= i_len);
    assign w_row_end = ((LEN_W'(r_col) + LEN_W'(1)) >= i_len);
    assign w_last    = (({1'b0, r_row} + 17'd1) >= {1'b0, i_rows});
    assign w_mem_we  = i_accept && w_is_load;
    assign w_mem_re  = i_accept && !w_is_load && w_full;
    // a load past a full store restarts the pass at element 0
    assign w_waddr   = w_full ? '0 : r_load_pos[AW-1:0];

    always_comb begin
        n_load_pos   = r_load_pos;
        n_col        = r_col;
        n_row        = r_row;
        n_pend_valid = 1'b0;
        n_pend_clear = 1'b0;
        n_pend_end   = 1'b0;
        n_pend_last  = 1'b0;
        if (i_accept) begin
            if (w_is_load) begin
                if (w_full) begin
                    n_load_pos   = LEN_W'(1);
                    n_col        = '0;
                    n_row        = '0;
                    n_pend_valid = 1'b1;
                    n_pend_clear = 1'b1;
                end else begin
                    n_load_pos = r_load_pos + LEN_W'(1);
                end
            end else if (w_full) begin
                n_pend_valid = 1'b1;
                n_pend_end   = w_row_end;
                n_pend_last  = w_last;
                if (w_row_end) begin
                    n_col = '0;
                    n_row = w_last ? '0 : r_row + ROW_W'(1);
                end else begin
                    n_col = r_col + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr] <= i_activation;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos   <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_load_pos   <= n_load_pos;
            r_col        <= n_col;
            r_row        <= n_row;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_clear <= n_pend_clear;
        r_pend_end   <= n_pend_end;
        r_pend_last  <= n_pend_last;
        if (i_accept) begin
            r_pend_trit  <= i_weight_trit;
            r_pend_scale <= i_row_scale;
            r_pend_row   <= r_row;
        end
    end

    assign o_pend = r_pend_valid;
    assign o_push = r_pend_valid;

    always_comb begin
        o_op.is_clear = r_pend_clear;
        o_op.trit     = r_pend_trit;
        o_op.data     = r_rd_data;
        o_op.scale    = r_pend_scale;
        o_op.row_end  = r_pend_end;
        o_op.last_row = r_pend_last;
        o_op.row_idx  = r_pend_row;
    end

endmodule

// File: rtl/tmv_queue.sv
// tmv_queue: short FIFO of operations between front and back.
// Depends on tmv_pkg.
`timescale 1ns / 1ps

module tmv_queue import tmv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_op               i_op,
    input  logic              i_pop,
    output logic              o_valid,
    output t_op               o_head,
    output logic [QCNT_W-1:0] o_level
);

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign o_level = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/tmv_back.sv
// tmv_back: accumulates activations per trit, scales the row sum, drives the result.
// Stages: accumulator -> multiply input register -> output register. Depends on tmv_pkg.
`timescale 1ns / 1ps

module tmv_back import tmv_pkg::*; #(
    parameter int MAX_VEC_LEN = 4096
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_op_valid,
    input  t_op                     i_op,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ROW_W-1:0]        o_row_index,
    output logic signed [RES_W-1:0] o_result_value,
    output logic                    o_last_row
);

    localparam int ACC_W  = ACT_W + $clog2(MAX_VEC_LEN) + 1;
    localparam int PROD_W = ACC_W + SCALE_W;
    localparam int EXT_W  = (PROD_W > RES_W + FRAC_SH) ? PROD_W : RES_W + FRAC_SH;

    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [ACC_W-1:0]   w_act;

    logic                      r_m_valid;
    logic signed [ACC_W-1:0]   r_m_sum;
    logic signed [SCALE_W-1:0] r_m_scale;
    logic [ROW_W-1:0]          r_m_row;
    logic                      r_m_last;

    logic                      r_o_valid;
    logic [ROW_W-1:0]          r_o_row;
    logic signed [RES_W-1:0]   r_o_value;
    logic                      r_o_last;

    logic                      w_o_can;
    logic                      w_m_can;
    logic                      w_m_move;
    logic                      w_m_load;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [EXT_W-1:0]   w_ext;

    assign w_o_can  = !r_o_valid || i_out_ready;
    assign w_m_move = r_m_valid && w_o_can;
    assign w_m_can  = !r_m_valid || w_o_can;
    // a row-ending weight needs room in the multiply stage
    assign o_pop    = i_op_valid && (i_op.is_clear || !i_op.row_end || w_m_can);
    assign w_m_load = o_pop && !i_op.is_clear && i_op.row_end;

    assign w_act = {{(ACC_W-ACT_W){i_op.data[ACT_W-1]}}, i_op.data};

    always_comb begin
        n_acc = r_acc;
        if (!i_op.is_clear) begin
            if (i_op.trit == TRIT_W'(1)) begin
                n_acc = r_acc + w_act;
            end else if (i_op.trit[TRIT_W-1]) begin
                n_acc = r_acc - w_act;
            end
        end
    end

    assign w_prod = PROD_W'(r_m_sum) * PROD_W'(r_m_scale);
    assign w_ext  = EXT_W'(w_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_acc <= (i_op.is_clear || i_op.row_end) ? '0 : n_acc;
            end
            if (w_m_load) begin
                r_m_valid <= 1'b1;
            end else if (w_m_move) begin
                r_m_valid <= 1'b0;
            end
            if (w_m_move) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_load) begin
            r_m_sum   <= n_acc;
            r_m_scale <= i_op.scale;
            r_m_row   <= i_op.row_idx;
            r_m_last  <= i_op.last_row;
        end
        if (w_m_move) begin
            r_o_row   <= r_m_row;
            r_o_value <= w_ext[RES_W+FRAC_SH-1:FRAC_SH];
            r_o_last  <= r_m_last;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_row_index    = r_o_row;
    assign o_result_value = r_o_value;
    assign o_last_row     = r_o_last;

endmodule

// File: rtl/ternary_weight_matvec_core.sv
// ternary_weight_matvec_core: top level of the ternary-weight matrix-vector product.
// Holds the config registers; instantiates tmv_front, tmv_queue, tmv_back. Depends on tmv_pkg.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------------------
//   input    | i_in_valid / o_in_ready    | i_cmd, i_activation, i_weight_trit, i_row_scale
//   result   | o_out_valid / i_out_ready  | o_row_index, o_result_value, o_last_row
//   config   | i_cfg_wr_en                | i_cfg_idx, i_cfg_data
//
// One item per cycle while the queue has room; the store takes one load write or one weight
// read a cycle. From a row's last weight to its result the path runs through the store read,
// the queue, the multiply input register and the output register.
// Reset is synchronous, active low; the activation store is not cleared.
// The four-entry queue lets the front keep accepting while the result side is stalled.
`timescale 1ns / 1ps

module ternary_weight_matvec_core import tmv_pkg::*; #(
    parameter int MAX_VEC_LEN = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic                      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_cmd,
    input  logic signed [ACT_W-1:0]   i_activation,
    input  logic signed [TRIT_W-1:0]  i_weight_trit,
    input  logic signed [SCALE_W-1:0] i_row_scale,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [ROW_W-1:0]          o_row_index,
    output logic signed [RES_W-1:0]   o_result_value,
    output logic                      o_last_row
);

    localparam int LEN_W = $clog2(MAX_VEC_LEN + 1);

    logic [VLEN_W-1:0] r_vec_len;
    logic [ROW_W-1:0]  r_row_count;

    logic [LEN_W-1:0]  w_len;
    logic [ROW_W-1:0]  w_rows;
    logic              w_accept;
    logic              w_pend;
    logic              w_push;
    t_op               w_push_op;
    logic              w_q_valid;
    t_op               w_q_head;
    logic [QCNT_W-1:0] w_q_level;
    logic              w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_len   <= VLEN_W'(4096);
            r_row_count <= ROW_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_VEC_LEN:   r_vec_len   <= i_cfg_data[VLEN_W-1:0];
                CFG_ROW_COUNT: r_row_count <= i_cfg_data[ROW_W-1:0];
                default:       ;
            endcase
        end
    end

    // zero length acts as one, oversize clamps to the store depth
    always_comb begin
        if (r_vec_len == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_vec_len) > 32'(MAX_VEC_LEN)) begin
            w_len = LEN_W'(MAX_VEC_LEN);
        end else begin
            w_len = LEN_W'(r_vec_len);
        end
    end

    assign w_rows = (r_row_count == '0) ? ROW_W'(1) : r_row_count;

    // room for the item in the store read stage plus this one
    assign o_in_ready = ((QCNT_W+1)'(w_q_level) + (QCNT_W+1)'(w_pend))
                        < (QCNT_W+1)'(QUEUE_DEPTH);
    assign w_accept   = i_in_valid && o_in_ready;

    tmv_front #(
        .MAX_VEC_LEN (MAX_VEC_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_cmd         (i_cmd),
        .i_activation  (i_activation),
        .i_weight_trit (i_weight_trit),
        .i_row_scale   (i_row_scale),
        .i_len         (w_len),
        .i_rows        (w_rows),
        .o_pend        (w_pend),
        .o_push        (w_push),
        .o_op          (w_push_op)
    );

    tmv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_q_head),
        .o_level (w_q_level)
    );

    tmv_back #(
        .MAX_VEC_LEN (MAX_VEC_LEN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op_valid     (w_q_valid),
        .i_op           (w_q_head),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_row_index    (o_row_index),
        .o_result_value (o_result_value),
        .o_last_row     (o_last_row)
    );

endmodule
